// ===== rtl/fmee_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmee_pkg: shared types and constants of the flight mode energy estimator
// Mode codes, register indexes, reset values, sequencer states and the
// command/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package fmee_pkg;

  typedef enum logic [2:0] {
    MODE_STOP    = 3'd0,
    MODE_HOVER   = 3'd1,
    MODE_ASCEND  = 3'd2,
    MODE_DESCEND = 3'd3,
    MODE_MOVE    = 3'd4
  } mode_t;

  localparam logic [2:0] REG_ASCEND  = 3'd0;
  localparam logic [2:0] REG_DESCEND = 3'd1;
  localparam logic [2:0] REG_MOVE    = 3'd2;
  localparam logic [2:0] REG_HOVER   = 3'd3;
  localparam logic [2:0] REG_SUPPLY  = 3'd4;

  localparam logic [15:0] ASCEND_RESET  = 16'd16000;
  localparam logic [15:0] DESCEND_RESET = 16'd13440;
  localparam logic [15:0] MOVE_RESET    = 16'd14080;
  localparam logic [31:0] HOVER_RESET   = 32'd13762560;

  // Root of a 48 bit radicand gives 24 bits; the quotient needs 34 bits.
  localparam int SQRT_STEPS = 24;
  localparam int DIV_STEPS  = 34;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENERGY1,
    ST_ENERGY2,
    ST_ENERGY3,
    ST_SQ,
    ST_ITER,
    ST_MOVE_MUL,
    ST_VERT_MUL,
    ST_SUM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic energy1;
    logic energy2;
    logic energy3;
    logic square;
    logic iter_init;
    logic iter_step;
    logic move_mul;
    logic vert_mul;
    logic sum;
  } dp_cmd_t;

  typedef struct packed {
    logic iter_done;
  } dp_status_t;

endpackage

// ===== rtl/fmee_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmee_in_if / fmee_out_if: valid/ready channels of the estimator
// Input items carry velocity, ground flag and elapsed time; result items
// carry the mode, current and energy.
// ----------------------------------------------------------------------------
interface fmee_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] vel_z;
  logic               at_ground;
  logic [31:0]        elapsed_us;
  modport source (output valid, vel_x, vel_y, vel_z, at_ground, elapsed_us,
                  input ready);
  modport sink (input valid, vel_x, vel_y, vel_z, at_ground, elapsed_us,
                output ready);
endinterface

interface fmee_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic        mode_changed;
  logic [31:0] current_draw;
  logic        current_saturated;
  logic [63:0] total_energy;
  modport source (output valid, mode, mode_changed, current_draw,
                  current_saturated, total_energy, input ready);
  modport sink (input valid, mode, mode_changed, current_draw,
                current_saturated, total_energy, output ready);
endinterface

// ===== rtl/fmee_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmee_ctrl: item sequencer
// Steps one item through the energy charge, the shared root/divide loop,
// the current products and the result register.
// ----------------------------------------------------------------------------
module fmee_ctrl
  import fmee_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_ENERGY1;
        end
      end
      ST_ENERGY1: begin
        cmd.energy1 = 1'b1;
        state_next  = ST_ENERGY2;
      end
      ST_ENERGY2: begin
        cmd.energy2 = 1'b1;
        state_next  = ST_ENERGY3;
      end
      ST_ENERGY3: begin
        cmd.energy3 = 1'b1;
        state_next  = ST_SQ;
      end
      ST_SQ: begin
        cmd.square = 1'b1;
        state_next = ST_ITER;
      end
      ST_ITER: begin
        if (status.iter_done) begin
          state_next = ST_MOVE_MUL;
        end else begin
          cmd.iter_step = 1'b1;
        end
      end
      ST_MOVE_MUL: begin
        cmd.move_mul = 1'b1;
        state_next   = ST_VERT_MUL;
      end
      ST_VERT_MUL: begin
        cmd.vert_mul = 1'b1;
        state_next   = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    cmd.iter_init = cmd.square;
  end

endmodule

// ===== rtl/fmee_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmee_dp: estimator datapath
// Energy products, bit-serial square root and restoring divider running
// side by side, current products, saturation and the mode state.
// ----------------------------------------------------------------------------
module fmee_dp
  import fmee_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic signed [15:0] vel_z,
  input  logic               at_ground,
  input  logic [31:0]        elapsed_us,
  input  logic [15:0]        ascend_factor,
  input  logic [15:0]        descend_factor,
  input  logic [15:0]        move_factor,
  input  logic [31:0]        hover_current,
  input  logic [15:0]        supply_voltage,
  output logic [2:0]         mode,
  output logic               mode_changed,
  output logic [31:0]        current_draw,
  output logic               current_saturated,
  output logic [63:0]        total_energy
);

  // Captured item.
  logic signed [15:0] vx, vy, vz;
  logic               ground;
  logic [31:0]        elapsed;

  // Machine state.
  logic [2:0]  present_mode;
  logic [31:0] present_current;
  logic [63:0] energy_total;

  // Energy path.
  logic [63:0] prod_p;
  logic [47:0] prod_hi, prod_lo;

  // Square root and divider.
  logic [31:0] sq_x, sq_y;
  logic [49:0] rad;       // radicand, shifted out two bits a step
  logic [25:0] rem_s;
  logic [23:0] root;
  logic [33:0] dividend;  // shifted out one bit a step
  logic [16:0] rem_d;
  logic [33:0] quot;
  logic [5:0]  step;
  logic [15:0] zmag;

  // Current path.
  logic [39:0] move_prod;
  logic [33:0] vert_part;
  logic [34:0] cur_sum;

  logic [25:0] s_trial;
  logic [25:0] s_rem_sh;
  logic [17:0] d_rem_sh;

  assign zmag = vz[15] ? 16'(-vz) : 16'(vz);
  assign status.iter_done = (step == 6'(DIV_STEPS));

  always_comb begin
    s_rem_sh = {rem_s[23:0], rad[49:48]};
    s_trial  = {root, 2'b01};
    d_rem_sh = {rem_d, dividend[33]};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vx      <= vel_x;
      vy      <= vel_y;
      vz      <= vel_z;
      ground  <= at_ground;
      elapsed <= elapsed_us;
    end
    if (cmd.energy1) begin
      prod_p <= 64'(elapsed) * 64'(present_current);
    end
    if (cmd.energy2) begin
      prod_hi <= prod_p[63:32] * 48'(supply_voltage);
      prod_lo <= prod_p[31:0] * 48'(supply_voltage);
      sq_x    <= 32'(vx * vx);
      sq_y    <= 32'(vy * vy);
    end
    if (cmd.square) begin
      rad      <= {2'b00, 32'(33'(sq_x) + 33'(sq_y)), 16'h0} ;
      rem_s    <= '0;
      root     <= '0;
      dividend <= {descend_factor, 18'h0};
      rem_d    <= '0;
      quot     <= '0;
    end
    if (cmd.iter_step) begin
      if (step < 6'(SQRT_STEPS + 1)) begin
        rad <= {rad[47:0], 2'b00};
        if (s_rem_sh >= s_trial) begin
          rem_s <= s_rem_sh - s_trial;
          root  <= {root[22:0], 1'b1};
        end else begin
          rem_s <= s_rem_sh;
          root  <= {root[22:0], 1'b0};
        end
      end
      dividend <= {dividend[32:0], 1'b0};
      if (d_rem_sh >= 18'(zmag)) begin
        rem_d <= 17'(d_rem_sh - 18'(zmag));
        quot  <= {quot[32:0], 1'b1};
      end else begin
        rem_d <= 17'(d_rem_sh);
        quot  <= {quot[32:0], 1'b0};
      end
    end
    if (cmd.move_mul) begin
      move_prod <= 40'(root) * 40'(move_factor);
    end
    if (cmd.vert_mul) begin
      if (vz[15]) begin
        vert_part <= quot;
      end else begin
        vert_part <= {32'(ascend_factor) * 32'(zmag), 2'b00};
      end
    end
  end

  // The radicand is 32 bits plus 16 fraction bits; the upper pad keeps it in
  // a 50 bit shift line, and the loop consumes its top two bits per step.
  // Sum of squares is at most 2^31, so it always fits in 32 bits.

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (cmd.iter_init) begin
      step <= '0;
    end else if (cmd.iter_step) begin
      step <= step + 6'd1;
    end
  end

  always_comb begin
    cur_sum = '0;
    if (vx != 0 || vy != 0) begin
      cur_sum = 35'(move_prod[39:6]) + ((vz == 0) ? 35'd0 : 35'(vert_part));
    end else if (vz != 0) begin
      cur_sum = 35'(vert_part);
    end else if (!ground) begin
      cur_sum = 35'(hover_current);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present_mode    <= MODE_STOP;
      present_current <= '0;
      energy_total    <= '0;
    end else begin
      if (cmd.energy3) begin
        energy_total <= total_energy;
      end
      if (cmd.sum) begin
        present_mode    <= mode;
        present_current <= current_draw;
      end
    end
  end

  // Shared combinational results: energy sum at energy3, the current at sum.
  logic [64:0] e_sum;
  logic [63:0] e_delta;
  logic [2:0]  mode_c;
  logic [31:0] cur_c;
  logic        sat_c;
  logic [2:0]  mode_r;
  logic        changed_r;
  logic [31:0] cur_r;
  logic        sat_r;

  always_comb begin
    e_delta = ({16'h0, prod_hi} << 8) + 64'(prod_lo[47:24]);
    e_sum   = 65'(energy_total) + 65'(e_delta);
    if (vx != 0 || vy != 0) begin
      mode_c = MODE_MOVE;
    end else if (vz > 0) begin
      mode_c = MODE_ASCEND;
    end else if (vz < 0) begin
      mode_c = MODE_DESCEND;
    end else if (ground) begin
      mode_c = MODE_STOP;
    end else begin
      mode_c = MODE_HOVER;
    end
    sat_c = cur_sum[34] | cur_sum[33] | cur_sum[32];
    cur_c = sat_c ? 32'hFFFF_FFFF : cur_sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      mode_r    <= mode_c;
      changed_r <= (mode_c != present_mode);
      cur_r     <= cur_c;
      sat_r     <= sat_c;
    end
  end

  always_comb begin
    if (cmd.sum) begin
      mode         = mode_c;
      current_draw = cur_c;
    end else begin
      mode         = mode_r;
      current_draw = cur_r;
    end
    mode_changed      = changed_r;
    current_saturated = sat_r;
    total_energy      = cmd.energy3 ? (e_sum[64] ? '1 : e_sum[63:0]) : energy_total;
  end

endmodule

// ===== rtl/fmee_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmee_regs: configuration register file
// APB write and read of the five factor and supply registers.
// ----------------------------------------------------------------------------
module fmee_regs
  import fmee_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] ascend_factor,
  output logic [15:0] descend_factor,
  output logic [15:0] move_factor,
  output logic [31:0] hover_current,
  output logic [15:0] supply_voltage
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      ascend_factor  <= ASCEND_RESET;
      descend_factor <= DESCEND_RESET;
      move_factor    <= MOVE_RESET;
      hover_current  <= HOVER_RESET;
      supply_voltage <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_ASCEND:  ascend_factor  <= pwdata[15:0];
        REG_DESCEND: descend_factor <= pwdata[15:0];
        REG_MOVE:    move_factor    <= pwdata[15:0];
        REG_HOVER:   hover_current  <= pwdata;
        REG_SUPPLY:  supply_voltage <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ASCEND:  prdata = {16'h0, ascend_factor};
      REG_DESCEND: prdata = {16'h0, descend_factor};
      REG_MOVE:    prdata = {16'h0, move_factor};
      REG_HOVER:   prdata = hover_current;
      REG_SUPPLY:  prdata = {16'h0, supply_voltage};
      default:     prdata = '0;
    endcase
  end

endmodule

// ===== rtl/flight_mode_energy_estimator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flight_mode_energy_estimator: top level
// Charges energy at the previous current, classifies the flight mode and
// computes the new current draw for each item.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  in_ch    | in  | vel_x, vel_y, vel_z, at_ground, elapsed_us
//  out_ch   | out | mode, mode_changed, current_draw, current_saturated,
//           |     | total_energy
//  apb      | in  | five 32 bit registers at 0x00..0x10
//
// One item runs from acceptance through the energy charge and the
// 34 step restoring divider, which sets the loop and runs beside the
// square root, to a valid result. Accepts the next item once the
// result is taken, so items never overlap. A stalled result holds.
// Reset is synchronous and restores the register defaults, zero energy,
// zero current and stop mode.
// ----------------------------------------------------------------------------
module flight_mode_energy_estimator
  import fmee_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  fmee_in_if.sink     in_ch,
  fmee_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dp_cmd_t     cmd;
  dp_status_t  status;
  logic [15:0] ascend_factor, descend_factor, move_factor, supply_voltage;
  logic [31:0] hover_current;

  fmee_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .ascend_factor, .descend_factor, .move_factor, .hover_current,
    .supply_voltage
  );

  fmee_ctrl u_ctrl (
    .clk, .rst,
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd, .status
  );

  fmee_dp u_dp (
    .clk, .rst, .cmd, .status,
    .vel_x             (in_ch.vel_x),
    .vel_y             (in_ch.vel_y),
    .vel_z             (in_ch.vel_z),
    .at_ground         (in_ch.at_ground),
    .elapsed_us        (in_ch.elapsed_us),
    .ascend_factor, .descend_factor, .move_factor, .hover_current,
    .supply_voltage,
    .mode              (out_ch.mode),
    .mode_changed      (out_ch.mode_changed),
    .current_draw      (out_ch.current_draw),
    .current_saturated (out_ch.current_saturated),
    .total_energy      (out_ch.total_energy)
  );

endmodule
